[sv/rcmm_pkg.sv]
// ============================================================================
// rcmm_pkg
// Shared constants and types for the real-by-complex matrix multiplier.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package rcmm_pkg;

    // Largest matrix dimensions held in the stores.
    localparam int MAX_M = 8;
    localparam int MAX_N = 8;

    // Field widths.
    localparam int IDX_W  = 3;   // row and column index
    localparam int SIZE_W = 4;   // m_size and n_size registers
    localparam int VAL_W  = 16;  // Q1.15 element
    localparam int PROD_W = 32;  // Q2.30 product
    localparam int ACC_W  = 36;  // Q6.30 sum of up to eight products

    // Store geometry: entries are addressed as {row, col} or {k, col}.
    localparam int A_DEPTH = MAX_M * MAX_M;
    localparam int B_DEPTH = MAX_M * MAX_N;
    localparam int A_AW    = $clog2(A_DEPTH);
    localparam int B_AW    = $clog2(B_DEPTH);

    // Stream word widths.
    localparam int S_DATA_W = 56;  // 54 bits of fields padded to bytes
    localparam int M_DATA_W = 80;  // 78 bits of fields padded to bytes
    localparam int OP_W     = 2;
    localparam int CFG_AW   = 1;

    // Operation codes carried in tuser.
    localparam logic [OP_W-1:0] OP_LOAD_A = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_B = 2'd1;
    localparam logic [OP_W-1:0] OP_START  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_AW-1:0] REG_M_SIZE = 1'b0;
    localparam logic [CFG_AW-1:0] REG_N_SIZE = 1'b1;

    // Tag that travels with each read through the multiply pipeline.
    typedef struct packed {
        logic             valid;  // a dot-product term is in this stage
        logic             first;  // first term of an element (k == 0)
        logic             final_term; // last term of an element
        logic             last;   // last element of the run
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } tag_t;

endpackage

`default_nettype wire

[sv/rcmm_ram.sv]
// ============================================================================
// rcmm_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module rcmm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read; the data holds while re is low.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[sv/real_complex_matrix_multiply.sv]
// A load word is written to its store as it is accepted; load words are taken one per
// cycle while idle. A start word issues one store read per product term, m*m*n reads in
// all at one per cycle unless the output stalls (one read port on each store); each C
// word is presented once its last term has passed the store read, product and output
// registers, and an output stall freezes the whole path. A new word is taken again
// once the last read has issued. Reset sets m_size and n_size to 8; stores not cleared.
// ============================================================================
// real_complex_matrix_multiply
// Multiplies a real M-by-M matrix A by a complex M-by-N matrix B out of two
// on-chip stores and streams C column by column.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module real_complex_matrix_multiply (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // Configuration write port.
    input  wire logic                               cfg_we,
    input  wire logic [rcmm_pkg::CFG_AW-1:0]        cfg_addr,
    input  wire logic [rcmm_pkg::SIZE_W-1:0]        cfg_data,
    // Input stream.
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // s_tdata: row_index[2:0], col_index[5:3], a_value[21:6],
    //          b_real[37:22], b_imag[53:38], zero padding[55:54]
    input  wire logic [rcmm_pkg::S_DATA_W-1:0]      s_tdata,
    // s_tuser: operation[1:0]
    input  wire logic [rcmm_pkg::OP_W-1:0]          s_tuser,
    // Output stream.
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // m_tdata: out_row[2:0], out_col[5:3], c_real[41:6], c_imag[77:42],
    //          zero padding[79:78]
    output logic      [rcmm_pkg::M_DATA_W-1:0]      m_tdata,
    output logic                                    m_tlast
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    // Input word fields.
    logic [rcmm_pkg::IDX_W-1:0] in_row;
    logic [rcmm_pkg::IDX_W-1:0] in_col;
    logic [rcmm_pkg::VAL_W-1:0] in_a;
    logic [rcmm_pkg::VAL_W-1:0] in_br;
    logic [rcmm_pkg::VAL_W-1:0] in_bi;

    assign in_row = s_tdata[2:0];
    assign in_col = s_tdata[5:3];
    assign in_a   = s_tdata[21:6];
    assign in_br  = s_tdata[37:22];
    assign in_bi  = s_tdata[53:38];

    // Configuration registers.
    logic [rcmm_pkg::SIZE_W-1:0] m_size_reg;
    logic [rcmm_pkg::SIZE_W-1:0] n_size_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_size_reg <= rcmm_pkg::SIZE_W'(rcmm_pkg::MAX_M);
            n_size_reg <= rcmm_pkg::SIZE_W'(rcmm_pkg::MAX_N);
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                rcmm_pkg::REG_M_SIZE: m_size_reg <= cfg_data;
                rcmm_pkg::REG_N_SIZE: n_size_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Sizes clamped to the store dimensions.
    logic [rcmm_pkg::SIZE_W-1:0] m_eff;
    logic [rcmm_pkg::SIZE_W-1:0] n_eff;

    assign m_eff = (m_size_reg > rcmm_pkg::SIZE_W'(rcmm_pkg::MAX_M)) ?
                   rcmm_pkg::SIZE_W'(rcmm_pkg::MAX_M) : m_size_reg;
    assign n_eff = (n_size_reg > rcmm_pkg::SIZE_W'(rcmm_pkg::MAX_N)) ?
                   rcmm_pkg::SIZE_W'(rcmm_pkg::MAX_N) : n_size_reg;

    // Pipeline advance: the whole read/multiply/accumulate path moves only
    // when the output register is free or being emptied.
    logic adv;
    assign adv = !m_tvalid || m_tready;

    // Sequencer state.
    logic                        state_reg, state_next;
    logic [rcmm_pkg::SIZE_W-1:0] m_run_reg, m_run_next;
    logic [rcmm_pkg::SIZE_W-1:0] n_run_reg, n_run_next;
    logic [rcmm_pkg::IDX_W-1:0]  k_reg, k_next;
    logic [rcmm_pkg::IDX_W-1:0]  i_reg, i_next;
    logic [rcmm_pkg::IDX_W-1:0]  j_reg, j_next;

    logic in_acc;
    logic k_end, i_end, j_end;
    logic issue;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign k_end    = ({1'b0, k_reg} == m_run_reg - 1'b1);
    assign i_end    = ({1'b0, i_reg} == m_run_reg - 1'b1);
    assign j_end    = ({1'b0, j_reg} == n_run_reg - 1'b1);
    assign issue    = (state_reg == ST_RUN) && adv;

    // Store writes from load words. Loads that fall outside the store are
    // dropped.
    logic a_we, b_we;
    assign a_we = in_acc && (s_tuser == rcmm_pkg::OP_LOAD_A)
               && ({1'b0, in_row} < rcmm_pkg::SIZE_W'(rcmm_pkg::MAX_M))
               && ({1'b0, in_col} < rcmm_pkg::SIZE_W'(rcmm_pkg::MAX_M));
    assign b_we = in_acc && (s_tuser == rcmm_pkg::OP_LOAD_B)
               && ({1'b0, in_row} < rcmm_pkg::SIZE_W'(rcmm_pkg::MAX_M))
               && ({1'b0, in_col} < rcmm_pkg::SIZE_W'(rcmm_pkg::MAX_N));

    // Sequencer: walks column j, row i and term k, one store read per cycle unless the output stalls.
    always_comb
    begin
        state_next = state_reg;
        m_run_next = m_run_reg;
        n_run_next = n_run_reg;
        k_next     = k_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && (s_tuser == rcmm_pkg::OP_START)
                    && (m_eff != '0) && (n_eff != '0))
                begin
                    state_next = ST_RUN;
                    m_run_next = m_eff;
                    n_run_next = n_eff;
                    k_next     = '0;
                    i_next     = '0;
                    j_next     = '0;
                end
            end
            ST_RUN:
            begin
                if (adv)
                begin
                    if (!k_end)
                    begin
                        k_next = k_reg + 1'b1;
                    end
                    else
                    begin
                        k_next = '0;
                        if (!i_end)
                        begin
                            i_next = i_reg + 1'b1;
                        end
                        else
                        begin
                            i_next = '0;
                            if (!j_end)
                            begin
                                j_next = j_reg + 1'b1;
                            end
                            else
                            begin
                                state_next = ST_IDLE;
                            end
                        end
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            m_run_reg <= '0;
            n_run_reg <= '0;
            k_reg     <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            m_run_reg <= m_run_next;
            n_run_reg <= n_run_next;
            k_reg     <= k_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
        end
    end

    // Stores: A is addressed {row, k}, B (imag over real) is addressed {k, col}.
    logic [rcmm_pkg::VAL_W-1:0]   a_rd;
    logic [2*rcmm_pkg::VAL_W-1:0] b_rd;

    rcmm_ram #(
        .WIDTH (rcmm_pkg::VAL_W),
        .DEPTH (rcmm_pkg::A_DEPTH)
    ) u_a_store (
        .clk   (clk),
        .we    (a_we),
        .waddr ({in_row, in_col}),
        .wdata (in_a),
        .re    (adv),
        .raddr ({i_reg, k_reg}),
        .rdata (a_rd)
    );

    rcmm_ram #(
        .WIDTH (2 * rcmm_pkg::VAL_W),
        .DEPTH (rcmm_pkg::B_DEPTH)
    ) u_b_store (
        .clk   (clk),
        .we    (b_we),
        .waddr ({in_row, in_col}),
        .wdata ({in_bi, in_br}),
        .re    (adv),
        .raddr ({k_reg, j_reg}),
        .rdata (b_rd)
    );

    // Tag stage 1 lines up with the store read data.
    rcmm_pkg::tag_t tag1_reg, tag1_next;

    always_comb
    begin
        tag1_next            = '0;
        tag1_next.valid      = issue;
        tag1_next.first      = (k_reg == '0);
        tag1_next.final_term = k_end;
        tag1_next.last       = k_end && i_end && j_end;
        tag1_next.row        = i_reg;
        tag1_next.col        = j_reg;
    end

    // Stage 2: registered products.
    rcmm_pkg::tag_t                     tag2_reg;
    logic signed [rcmm_pkg::PROD_W-1:0] pr_reg, pr_next;
    logic signed [rcmm_pkg::PROD_W-1:0] pi_reg, pi_next;

    assign pr_next = $signed(a_rd) * $signed(b_rd[rcmm_pkg::VAL_W-1:0]);
    assign pi_next = $signed(a_rd) * $signed(b_rd[2*rcmm_pkg::VAL_W-1:rcmm_pkg::VAL_W]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
        end
        else if (adv)
        begin
            tag1_reg <= tag1_next;
            tag2_reg <= tag1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pr_reg <= pr_next;
            pi_reg <= pi_next;
        end
    end

    // Stage 3: accumulate; the first term of an element restarts the sum.
    logic signed [rcmm_pkg::ACC_W-1:0] acc_r_reg, acc_r_next;
    logic signed [rcmm_pkg::ACC_W-1:0] acc_i_reg, acc_i_next;

    assign acc_r_next = (tag2_reg.first ? rcmm_pkg::ACC_W'(0) : acc_r_reg)
                      + rcmm_pkg::ACC_W'(pr_reg);
    assign acc_i_next = (tag2_reg.first ? rcmm_pkg::ACC_W'(0) : acc_i_reg)
                      + rcmm_pkg::ACC_W'(pi_reg);

    always_ff @(posedge clk)
    begin
        if (adv && tag2_reg.valid)
        begin
            acc_r_reg <= acc_r_next;
            acc_i_reg <= acc_i_next;
        end
    end

    // Output register: loaded with the finished sums of each element.
    logic out_load;
    assign out_load = adv && tag2_reg.valid && tag2_reg.final_term;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid <= 1'b0;
        end
        else if (out_load)
        begin
            m_tvalid <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_tdata <= {2'b00, acc_i_next, acc_r_next, tag2_reg.col, tag2_reg.row};
            m_tlast <= tag2_reg.last;
        end
    end

endmodule

`default_nettype wire
